### rtl/mfdr_pkg.sv
// Shared types and constants for the monochrome framebuffer with rotating flush.
// Holds the command codes, the item and result structs and the control links
// between controller and datapath. No dependencies.
package mfdr_pkg;

	typedef enum logic [2:0] {
		CMD_FILL  = 3'd0,
		CMD_PIXEL = 3'd1,
		CMD_HLINE = 3'd2,
		CMD_VLINE = 3'd3,
		CMD_RECT  = 3'd4,
		CMD_FRECT = 3'd5,
		CMD_FLUSH = 3'd6,
		CMD_NOP   = 3'd7
	} draw_cmd_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic signed [15:0] width;
		logic signed [15:0] height;
		logic               colour;
	} in_item_t;

	typedef struct packed {
		logic [63:0] pixel_word;
		logic [5:0]  word_index;
		logic        last;
	} out_item_t;

	// A drawing command breaks into at most three row spans.
	localparam int NUM_OPS = 3;
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] LAST_OP = OP_W'(NUM_OPS - 1);

	// Row offset of the final byte within one output word.
	localparam logic [2:0] LAST_BYTE = 3'd7;

	typedef struct packed {
		logic            load;
		logic            op_load;
		logic            rd_draw;
		logic            rd_flush;
		logic [OP_W-1:0] op_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [NUM_OPS-1:0] op_en;
		logic               row_last;
		logic               flush_last;
	} ctrl_sts_t;

endpackage

### rtl/mono_framebuffer_draw_rotate.sv
// Monochrome portrait framebuffer with drawing commands and a rotating flush.
// Top level: joins the controller and the datapath. Depends on mfdr_pkg,
// mfdr_ctrl and mfdr_datapath.
//
// Usage:
//   Command channel: drive item and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy stays high until the block
//   can take the next item.
//   Result channel: a flush emits LOGICAL_COLS*LOGICAL_ROWS/64 words (64 at the
//   default size). Each word sits on result for one cycle with strobe high;
//   the receiver cannot hold results off and must take every word as it comes.
//   Drawing commands and the unused code produce no result.
// Sequencing:
//   Drawing commands hold busy through the span arithmetic (ST_SUM, ST_CLIP),
//   a check of each of the three spans, a walk over the clipped rows of each
//   enabled span, one row at a time, and a drain; a fill walks every row.
//   The single read port of the row memory makes the walk go row by row.
//   A flush reads one row per output byte, then drains before busy falls.
// Reset: arst_n clears the control state and the per-row valid bits, so the
//   image reads as all black straight away; no clearing pass is needed.
module mono_framebuffer_draw_rotate #(
	parameter int LOGICAL_COLS = 32,
	parameter int LOGICAL_ROWS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mfdr_pkg::in_item_t  item,
	output mfdr_pkg::out_item_t result,
	output logic                strobe
);
	import mfdr_pkg::*;

	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	// Sequence the command: set-up, span walk or flush walk, then drain.
	mfdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item_cmd (item.cmd),
		.sts      (sts),
		.ctl      (ctl),
		.busy     (busy)
	);

	// Hold the image and build the rotated words.
	mfdr_datapath #(
		.COLS (LOGICAL_COLS),
		.ROWS (LOGICAL_ROWS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

endmodule

### rtl/mfdr_ctrl.sv
// Sequencer for the framebuffer: accepts a command, steps the row spans of a
// drawing command or the page and row walk of a flush. Depends on mfdr_pkg.
module mfdr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           item_cmd,
	input  mfdr_pkg::ctrl_sts_t  sts,
	output mfdr_pkg::ctrl_cmd_t  ctl,
	output logic                 busy
);
	import mfdr_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SUM   = 7'b0000010,
		ST_CLIP  = 7'b0000100,
		ST_LOAD  = 7'b0001000,
		ST_WALK  = 7'b0010000,
		ST_FLUSH = 7'b0100000,
		ST_DRAIN = 7'b1000000
	} ctl_state_t;

	ctl_state_t      state_q, state_d;
	logic [OP_W-1:0] op_sel_q, op_sel_d;

	always_comb begin
		state_d     = state_q;
		op_sel_d    = op_sel_q;
		ctl.load    = 1'b0;
		ctl.op_load = 1'b0;
		ctl.rd_draw = 1'b0;
		ctl.rd_flush = 1'b0;
		ctl.op_sel  = op_sel_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					if (item_cmd == CMD_FLUSH) begin
						state_d = ST_FLUSH;
					end else if (item_cmd == CMD_NOP) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				state_d = ST_CLIP;
			end
			ST_CLIP: begin
				op_sel_d = '0;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.op_en[op_sel_q]) begin
					ctl.op_load = 1'b1;
					state_d     = ST_WALK;
				end else if (op_sel_q == LAST_OP) begin
					state_d = ST_DRAIN;
				end else begin
					op_sel_d = op_sel_q + OP_W'(1);
				end
			end
			ST_WALK: begin
				ctl.rd_draw = 1'b1;
				if (sts.row_last) begin
					if (op_sel_q == LAST_OP) begin
						state_d = ST_DRAIN;
					end else begin
						op_sel_d = op_sel_q + OP_W'(1);
						state_d  = ST_LOAD;
					end
				end
			end
			ST_FLUSH: begin
				ctl.rd_flush = 1'b1;
				if (sts.flush_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_sel_q <= '0;
		end else begin
			state_q  <= state_d;
			op_sel_q <= op_sel_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	ap_walk_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> sts.op_en[op_sel_q])
		else $error("walking a row span that is not enabled");

	ap_drain_pred: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q) == ST_WALK || $past(state_q) == ST_FLUSH
			|| $past(state_q) == ST_LOAD)
		else $error("drain entered from an unexpected state");

	ap_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_draw && ctl.rd_flush))
		else $error("draw and flush reads issued together");

endmodule

### rtl/mfdr_datapath.sv
// Datapath of the framebuffer: item register, span arithmetic and clipping,
// row memory with read-modify-write, and the rotating flush word builder.
// Depends on mfdr_pkg.
module mfdr_datapath #(
	parameter int COLS = 32,
	parameter int ROWS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfdr_pkg::in_item_t   item,
	input  mfdr_pkg::ctrl_cmd_t  ctl,
	output mfdr_pkg::ctrl_sts_t  sts,
	output mfdr_pkg::out_item_t  result,
	output logic                 strobe
);
	import mfdr_pkg::*;

	localparam int COL_W = $clog2(COLS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int PAGES = COLS / 8;
	localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int WORDS = (COLS * ROWS) / 64;
	localparam int WC_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic signed [17:0] COL_MAX = 18'(COLS - 1);
	localparam logic signed [17:0] ROW_MAX = 18'(ROWS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [PG_W-1:0] PG_LAST = PG_W'(PAGES - 1);
	localparam logic [WC_W-1:0] WK_LAST = WC_W'(WORDS - 1);

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] lo;
		logic [ROW_W-1:0] hi;
	} row_rng_t;

	function automatic row_rng_t clip_rows(input logic gate, input logic signed [17:0] a,
		input logic signed [17:0] b);
		row_rng_t r;
		r.en = gate && (a <= ROW_MAX) && (b >= 18'sd0);
		r.lo = (a < 18'sd0) ? '0 : a[ROW_W-1:0];
		r.hi = (b > ROW_MAX) ? ROW_MAX[ROW_W-1:0] : b[ROW_W-1:0];
		return r;
	endfunction

	in_item_t          itm_q;
	logic signed [17:0] x18, y18, w18, h18, xr18, yb18;
	logic signed [17:0] xe_q, ye_q;
	logic              is_fill, is_pixel, is_hline, is_vline, is_rect, is_frect;
	logic              w_pos, h_pos, span_ok, x_ok, xr_ok;
	logic [COL_W-1:0]  ca, cb;
	logic [COLS-1:0]   span_mask, colx_mask, colr_mask, mask0;
	logic signed [17:0] a0, b0;
	logic              gate0;

	row_rng_t          op_q [NUM_OPS];
	logic [COLS-1:0]   op_mask_q [NUM_OPS];

	logic [COLS-1:0]   frame_q [ROWS];
	logic [ROWS-1:0]   valid_q;
	logic [ROW_W-1:0]  row_q;
	logic [PG_W-1:0]   page_q;
	logic [WC_W-1:0]   wk_q;
	logic [WC_W+5:0]   wk_ext;

	logic              drw_s1, fls_s1, vld_s1;
	logic [COLS-1:0]   rd_data_s1, mask_s1, base_s1, wr_data;
	logic [ROW_W-1:0]  row_s1;
	logic [PG_W-1:0]   page_s1;
	logic [7:0]        page_byte, byte_rev;
	logic [63:0]       acc_q;
	logic              emit;
	out_item_t         result_q;
	logic              strobe_q;

	// Hold the accepted item for the whole command.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			itm_q <= item;
		end
	end

	assign x18  = $signed({{2{itm_q.x_pos[15]}}, itm_q.x_pos});
	assign y18  = $signed({{2{itm_q.y_pos[15]}}, itm_q.y_pos});
	assign w18  = $signed({{2{itm_q.width[15]}}, itm_q.width});
	assign h18  = $signed({{2{itm_q.height[15]}}, itm_q.height});

	// Far edges as exact integers; the outline edges take their 16-bit wrap.
	always_ff @(posedge clk) begin
		xe_q <= x18 + w18 - 18'sd1;
		ye_q <= y18 + h18 - 18'sd1;
	end

	assign xr18 = $signed({{2{xe_q[15]}}, xe_q[15:0]});
	assign yb18 = $signed({{2{ye_q[15]}}, ye_q[15:0]});

	assign is_fill  = (itm_q.cmd == CMD_FILL);
	assign is_pixel = (itm_q.cmd == CMD_PIXEL);
	assign is_hline = (itm_q.cmd == CMD_HLINE);
	assign is_vline = (itm_q.cmd == CMD_VLINE);
	assign is_rect  = (itm_q.cmd == CMD_RECT);
	assign is_frect = (itm_q.cmd == CMD_FRECT);
	assign w_pos = !itm_q.width[15] && (itm_q.width != 16'sd0);
	assign h_pos = !itm_q.height[15] && (itm_q.height != 16'sd0);

	// Column masks, clipped to the image.
	assign span_ok = (x18 <= COL_MAX) && (xe_q >= 18'sd0);
	assign ca = (x18 < 18'sd0) ? '0 : x18[COL_W-1:0];
	assign cb = (xe_q > COL_MAX) ? COL_MAX[COL_W-1:0] : xe_q[COL_W-1:0];
	assign x_ok  = (x18 >= 18'sd0) && (x18 <= COL_MAX);
	assign xr_ok = (xr18 >= 18'sd0) && (xr18 <= COL_MAX);

	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			span_mask[i] = span_ok && (COL_W'(i) >= ca) && (COL_W'(i) <= cb);
			colx_mask[i] = x_ok && (x18[COL_W-1:0] == COL_W'(i));
			colr_mask[i] = xr_ok && (xr18[COL_W-1:0] == COL_W'(i));
		end
	end

	assign gate0 = is_fill || is_pixel || (is_hline && w_pos) || (is_vline && h_pos)
		|| (is_rect && w_pos) || (is_frect && w_pos && h_pos);
	assign a0 = is_fill ? 18'sd0 : y18;
	assign b0 = is_fill ? ROW_MAX : ((is_vline || is_frect) ? ye_q : y18);
	assign mask0 = is_fill ? '1 : ((is_pixel || is_vline) ? colx_mask : span_mask);

	// Span 0: the command's main span. Spans 1 and 2: outline bottom edge and sides.
	always_ff @(posedge clk) begin
		op_q[0]      <= clip_rows(gate0, a0, b0);
		op_mask_q[0] <= mask0;
		op_q[1]      <= clip_rows(is_rect && w_pos, yb18, yb18);
		op_mask_q[1] <= span_mask;
		op_q[2]      <= clip_rows(is_rect && h_pos, y18, ye_q);
		op_mask_q[2] <= colx_mask | colr_mask;
	end

	always_comb begin
		for (int k = 0; k < NUM_OPS; k++) begin
			sts.op_en[k] = op_q[k].en;
		end
		sts.row_last   = (row_q == op_q[ctl.op_sel].hi);
		sts.flush_last = (row_q == ROW_LAST) && (page_q == PG_LAST);
	end

	// Row, page and word counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			page_q <= '0;
			wk_q   <= '0;
		end else begin
			if (ctl.load) begin
				row_q  <= '0;
				page_q <= '0;
				wk_q   <= '0;
			end else if (ctl.op_load) begin
				row_q <= op_q[ctl.op_sel].lo;
			end else if (ctl.rd_draw) begin
				row_q <= row_q + ROW_W'(1);
			end else if (ctl.rd_flush) begin
				if (row_q == ROW_LAST) begin
					row_q  <= '0;
					page_q <= page_q + PG_W'(1);
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
			if (emit) begin
				wk_q <= wk_q + WC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drw_s1  <= 1'b0;
			fls_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			drw_s1 <= ctl.rd_draw;
			fls_s1 <= ctl.rd_flush;
			if (drw_s1) begin
				valid_q[row_s1] <= 1'b1;
			end
		end
	end

	// Row memory: one registered read, one write a cycle.
	always_ff @(posedge clk) begin
		if (ctl.rd_draw || ctl.rd_flush) begin
			rd_data_s1 <= frame_q[row_q];
			vld_s1     <= valid_q[row_q];
			row_s1     <= row_q;
			page_s1    <= page_q;
			mask_s1    <= op_mask_q[ctl.op_sel];
		end
		if (drw_s1) begin
			frame_q[row_s1] <= wr_data;
		end
	end

	assign base_s1 = vld_s1 ? rd_data_s1 : '0;
	assign wr_data = itm_q.colour ? (base_s1 | mask_s1) : (base_s1 & ~mask_s1);

	// Pick the page's eight columns, leftmost column into bit 7.
	always_comb begin
		page_byte = '0;
		for (int p = 0; p < PAGES; p++) begin
			if (page_s1 == PG_W'(p)) begin
				page_byte = base_s1[COLS-1-8*p -: 8];
			end
		end
		for (int b = 0; b < 8; b++) begin
			byte_rev[b] = page_byte[7-b];
		end
	end

	assign emit   = fls_s1 && (row_s1[2:0] == LAST_BYTE);
	assign wk_ext = {6'd0, wk_q};

	always_ff @(posedge clk) begin
		if (fls_s1) begin
			acc_q <= {byte_rev, acc_q[63:8]};
		end
		if (emit) begin
			result_q.pixel_word <= {byte_rev, acc_q[63:8]};
			result_q.word_index <= wk_ext[5:0];
			result_q.last       <= (wk_q == WK_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

	ap_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(drw_s1 && fls_s1))
		else $error("memory write and flush read in flight together");

	ap_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(fls_s1))
		else $error("result strobe without a flush read behind it");

	ap_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> !fls_s1)
		else $error("flush reads continue past the final word");

endmodule
